@@ rtl/kce_pkg.sv @@
// Shared constants, types and cell control bundle for the k-combination enumerator.
package kce_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS + 1);
    localparam int POS_W     = $clog2(MAX_ITEMS);

    typedef enum logic [1:0] {
        TAG_KEEP,
        TAG_BUMP,
        TAG_FOLLOW,
        TAG_FIRST
    } tag_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PREP,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] base;
        logic             final_sub;
        logic [IDX_W-1:0] tail_value;
    } cell_ctrl_t;

endpackage

@@ rtl/k_combination_enumerator.sv @@
// Top level of the k-combination enumerator: register port, sequencer and output register.
// An accepted request passes through the prepare state and the emit state to the output register.
// A request gives one index per cycle while the receiver is ready, as the subset
// rotates once through the cell chain; a bad setting gives its single beat from the bad state.
// Reset (synchronous, active low) sets N to 8 and K to 3 and marks the subset unloaded,
// so the next request starts at the first subset; there is no clearing pass.
module k_combination_enumerator import kce_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] item_index, [7] zero
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [0] final_subset, [1] bad_setting
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_EMIT,
        ST_BAD
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] item_count_reg, item_count_next;
    logic [IDX_W-1:0] subset_size_reg, subset_size_next;
    logic             loaded_reg, loaded_next;
    logic             final_reg, final_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [IDX_W-1:0] m_index_reg, m_index_next;
    logic             m_last_reg, m_last_next;
    logic             m_final_reg, m_final_next;
    logic             m_bad_reg, m_bad_next;

    logic             cfg_write;
    logic             in_beat;
    logic             slot_free;
    logic [IDX_W-1:0] n_eff;
    logic             bad;
    cell_op_t         op;
    logic [IDX_W-1:0] head_value;
    logic             final_sub;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = paddr[2] ? {{(32 - IDX_W){1'b0}}, subset_size_reg}
                                : {{(32 - IDX_W){1'b0}}, item_count_reg};

    assign n_eff = (item_count_reg > IDX_W'(MAX_ITEMS)) ? IDX_W'(MAX_ITEMS) : item_count_reg;
    assign bad   = (subset_size_reg == '0) || (n_eff == '0) || (subset_size_reg > n_eff);

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        item_count_next  = item_count_reg;
        subset_size_next = subset_size_reg;
        loaded_next      = loaded_reg;
        final_next       = final_reg;
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_index_next     = m_index_reg;
        m_last_next      = m_last_reg;
        m_final_next     = m_final_reg;
        m_bad_next       = m_bad_reg;
        op               = CELL_HOLD;

        if (cfg_write) begin
            if (paddr[2]) begin
                subset_size_next = pwdata[IDX_W-1:0];
            end else begin
                item_count_next = pwdata[IDX_W-1:0];
            end
            loaded_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    if (bad) begin
                        loaded_next = 1'b0;
                        state_next  = ST_BAD;
                    end else begin
                        if (s_tdata[0] || !loaded_reg) begin
                            op          = CELL_LOAD;
                            loaded_next = 1'b1;
                        end
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                op         = CELL_PREP;
                final_next = final_sub;
                cnt_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    op           = CELL_SHIFT;
                    m_valid_next = 1'b1;
                    m_index_next = head_value;
                    m_last_next  = (cnt_reg == subset_size_reg - IDX_W'(1));
                    m_final_next = final_reg;
                    m_bad_next   = 1'b0;
                    cnt_next     = cnt_reg + IDX_W'(1);
                    if (cnt_reg == subset_size_reg - IDX_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAD: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_index_next = '0;
                    m_last_next  = 1'b1;
                    m_final_next = 1'b0;
                    m_bad_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            item_count_reg  <= IDX_W'(8);
            subset_size_reg <= IDX_W'(3);
            loaded_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            item_count_reg  <= item_count_next;
            subset_size_reg <= subset_size_next;
            loaded_reg      <= loaded_next;
            m_valid_reg     <= m_valid_next;
        end
        final_reg   <= final_next;
        cnt_reg     <= cnt_next;
        m_index_reg <= m_index_next;
        m_last_reg  <= m_last_next;
        m_final_reg <= m_final_next;
        m_bad_reg   <= m_bad_next;
    end

    kce_chain u_chain (
        .aclk        (aclk),
        .op          (op),
        .item_count  (n_eff),
        .subset_size (subset_size_reg),
        .head_value  (head_value),
        .final_sub   (final_sub)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - IDX_W){1'b0}}, m_index_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_bad_reg, m_final_reg};

endmodule

@@ rtl/kce_cell.sv @@
// One cell of the chain: holds one selected index of the current subset and its advance tag.
module kce_cell import kce_pkg::*; (
    input  logic             aclk,
    input  logic [POS_W-1:0] pos,
    input  cell_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] nbr_value,
    input  tag_t             nbr_tag,
    input  logic             nbr_at_max,
    output logic [IDX_W-1:0] value,
    output tag_t             tag,
    output logic             at_max
);

    logic [IDX_W-1:0] value_reg, value_next;
    tag_t             tag_reg, tag_next;
    logic             active;
    logic             is_tail;
    logic [IDX_W:0]   limit;

    assign active  = IDX_W'(pos) < ctrl.k;
    assign is_tail = IDX_W'(pos) == (ctrl.k - IDX_W'(1));
    assign limit   = {1'b0, ctrl.base} + (IDX_W + 1)'(pos);
    assign at_max  = !active || ({1'b0, value_reg} == limit);

    always_comb begin
        value_next = value_reg;
        tag_next   = tag_reg;
        unique case (ctrl.op)
            CELL_HOLD: begin
            end
            CELL_LOAD: begin
                value_next = IDX_W'(pos) + IDX_W'(1);
            end
            CELL_PREP: begin
                if (ctrl.final_sub) begin
                    tag_next = (pos == '0) ? TAG_FIRST : TAG_FOLLOW;
                end else if (at_max) begin
                    tag_next = TAG_FOLLOW;
                end else if (nbr_at_max) begin
                    tag_next = TAG_BUMP;
                end else begin
                    tag_next = TAG_KEEP;
                end
            end
            CELL_SHIFT: begin
                if (active) begin
                    if (is_tail) begin
                        value_next = ctrl.tail_value;
                        tag_next   = TAG_KEEP;
                    end else begin
                        value_next = nbr_value;
                        tag_next   = nbr_tag;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        tag_reg   <= tag_next;
    end

    assign value = value_reg;
    assign tag   = tag_reg;

endmodule

@@ rtl/kce_chain.sv @@
// Row of index cells with the rotation feedback that rewrites each index as it re-enters the tail.
module kce_chain import kce_pkg::*; (
    input  logic             aclk,
    input  cell_op_t         op,
    input  logic [IDX_W-1:0] item_count,
    input  logic [IDX_W-1:0] subset_size,
    output logic [IDX_W-1:0] head_value,
    output logic             final_sub
);

    logic [IDX_W-1:0] cell_value [MAX_ITEMS];
    tag_t             cell_tag   [MAX_ITEMS];
    logic             cell_max   [MAX_ITEMS];
    cell_ctrl_t       ctrl;
    logic [IDX_W-1:0] prev_reg, prev_next;
    logic [IDX_W-1:0] reinsert;

    always_comb begin
        unique case (cell_tag[0])
            TAG_KEEP:   reinsert = cell_value[0];
            TAG_BUMP:   reinsert = cell_value[0] + IDX_W'(1);
            TAG_FOLLOW: reinsert = prev_reg + IDX_W'(1);
            TAG_FIRST:  reinsert = IDX_W'(1);
            default:    reinsert = cell_value[0];
        endcase
        prev_next = (op == CELL_SHIFT) ? reinsert : prev_reg;
    end

    always_ff @(posedge aclk) begin
        prev_reg <= prev_next;
    end

    assign ctrl.op         = op;
    assign ctrl.k          = subset_size;
    assign ctrl.base       = item_count - subset_size + IDX_W'(1);
    assign ctrl.final_sub  = cell_max[0];
    assign ctrl.tail_value = reinsert;

    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        if (i == MAX_ITEMS - 1) begin : g_end
            kce_cell u_cell (
                .aclk       (aclk),
                .pos        (POS_W'(i)),
                .ctrl       (ctrl),
                .nbr_value  ('0),
                .nbr_tag    (TAG_KEEP),
                .nbr_at_max (1'b1),
                .value      (cell_value[i]),
                .tag        (cell_tag[i]),
                .at_max     (cell_max[i])
            );
        end else begin : g_mid
            kce_cell u_cell (
                .aclk       (aclk),
                .pos        (POS_W'(i)),
                .ctrl       (ctrl),
                .nbr_value  (cell_value[i+1]),
                .nbr_tag    (cell_tag[i+1]),
                .nbr_at_max (cell_max[i+1]),
                .value      (cell_value[i]),
                .tag        (cell_tag[i]),
                .at_max     (cell_max[i])
            );
        end
    end

    assign head_value = cell_value[0];
    assign final_sub  = cell_max[0];

endmodule

@@ verif/k_combination_enumerator_tb.sv @@
// Self-checking testbench for the k-combination enumerator, with a subset predictor and random traffic.

typedef enum int {
    REG_ITEM_COUNT  = 0,
    REG_SUBSET_SIZE = 1
} kce_reg_e;

typedef struct packed {
    logic [6:0] item_index;
    logic       last_of_subset;
    logic       final_subset;
    logic       bad_setting;
} index_beat_t;

class subset_predictor;
    logic [6:0]  item_count;
    logic [6:0]  subset_size;
    logic [63:0] selection;
    bit          loaded;
    index_beat_t due_indices[$];
    int          mismatches;

    function new();
        item_count  = 7'd8;
        subset_size = 7'd3;
        selection   = '0;
        loaded      = 1'b0;
        mismatches  = 0;
    endfunction

    function logic [63:0] ones_below(int unsigned w);
        if (w >= 64) begin
            return '1;
        end
        return (64'd1 << w) - 64'd1;
    endfunction

    function logic [63:0] next_selection(logic [63:0] m, int unsigned n, int unsigned k);
        int unsigned pos;
        int unsigned j;
        int unsigned above;
        for (pos = n - 1; pos >= 1; pos--) begin
            if (m[pos - 1] && !m[pos]) begin
                above = 0;
                for (j = pos; j < 64; j++) begin
                    above += 32'(m[j]);
                end
                return (m & ones_below(pos - 1)) | (ones_below(above + 1) << pos);
            end
        end
        return ones_below(k);
    endfunction

    function void write_register(kce_reg_e which, logic [31:0] value);
        case (which)
            REG_ITEM_COUNT: begin
                item_count = value[6:0];
                loaded     = 1'b0;
            end
            REG_SUBSET_SIZE: begin
                subset_size = value[6:0];
                loaded      = 1'b0;
            end
            default: begin
            end
        endcase
    endfunction

    function void note_request(bit restart);
        int unsigned n;
        int unsigned k;
        int unsigned i;
        int unsigned emitted;
        logic [63:0] last_mask;
        bit          is_last_subset;
        index_beat_t b;
        n = (item_count > 7'(kce_pkg::MAX_ITEMS)) ? 32'(kce_pkg::MAX_ITEMS) : 32'(item_count);
        k = 32'(subset_size);
        if (k == 0 || n == 0 || k > n) begin
            loaded = 1'b0;
            b = '0;
            b.last_of_subset = 1'b1;
            b.bad_setting = 1'b1;
            due_indices.push_back(b);
            return;
        end
        if (restart || !loaded) begin
            selection = ones_below(k);
            loaded = 1'b1;
        end
        last_mask = ones_below(n) & ~ones_below(n - k);
        is_last_subset = (selection == last_mask);
        emitted = 0;
        for (i = 0; i < n; i++) begin
            if (selection[i]) begin
                emitted++;
                b = '0;
                b.item_index = 7'(i + 1);
                b.final_subset = is_last_subset;
                b.last_of_subset = (emitted == k);
                due_indices.push_back(b);
            end
        end
        selection = is_last_subset ? ones_below(k) : next_selection(selection, n, k);
    endfunction

    function void note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $time, what);
        end
    endfunction

    function void check_beat(index_beat_t got);
        index_beat_t want;
        if (due_indices.size() == 0) begin
            note_mismatch($sformatf("unexpected beat: index %0d last %b final %b bad %b",
                got.item_index, got.last_of_subset, got.final_subset, got.bad_setting));
            return;
        end
        want = due_indices.pop_front();
        if (got !== want) begin
            note_mismatch($sformatf(
                "expected index %0d last %b final %b bad %b, got index %0d last %b final %b bad %b",
                want.item_index, want.last_of_subset, want.final_subset, want.bad_setting,
                got.item_index, got.last_of_subset, got.final_subset, got.bad_setting));
        end
    endfunction
endclass

module k_combination_enumerator_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 460;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [6:0] item_index, [7] zero
    logic        m_tlast;
    logic [1:0]  m_tuser;   // [0] final_subset, [1] bad_setting

    subset_predictor track;
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;
    int quiet_cycles = 0;

    k_combination_enumerator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin : monitor
        index_beat_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                track.note_request(s_tdata[0]);
            end
            if (m_tvalid && m_tready) begin
                got.item_index     = m_tdata[6:0];
                got.last_of_subset = m_tlast;
                got.final_subset   = m_tuser[0];
                got.bad_setting    = m_tuser[1];
                track.check_beat(got);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // The receiver stalls at random, or holds off completely for a counted stretch on request.
    initial begin : receiver
        int held;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) begin
                    @(posedge aclk);
                end
            end
            m_tready <= rx_steady || ($urandom_range(99) >= 24);
        end
    end

    function automatic int pick_gap();
        int g;
        g = 0;
        if (tx_steady) begin
            return 0;
        end
        while ($urandom_range(99) < 24) begin
            g++;
        end
        return g;
    endfunction

    task automatic send_request(input bit restart);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (track.due_indices.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input kce_reg_e which, input logic [6:0] value);
        logic [31:0] word;
        logic [31:0] byte_addr;
        word      = ($urandom() & ~32'h7f) | {25'd0, value};
        byte_addr = 4 * which;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= byte_addr[2:0];
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        track.write_register(which, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input logic [6:0] n_val, input logic [6:0] k_val);
        drain_results();
        write_reg(REG_ITEM_COUNT, n_val);
        write_reg(REG_SUBSET_SIZE, k_val);
    endtask

    initial begin : stimulus
        int sent;
        int phase;
        int phase_items;
        int j;
        int n_val;
        int k_val;
        track    = new();
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting, loaded by the first request, then a restart.
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b0);
        // Walk past the final subset so that the mask wraps.
        configure(7'd4, 7'd2);
        repeat (7) send_request(1'b0);
        configure(7'd4, 7'd4);
        send_request(1'b0);
        send_request(1'b1);
        configure(7'd3, 7'd5);
        send_request(1'b0);
        configure(7'd0, 7'd2);
        send_request(1'b0);
        configure(7'd5, 7'd0);
        send_request(1'b1);
        // Rewriting a register with its own value still restarts the enumeration.
        configure(7'd5, 7'd2);
        repeat (3) send_request(1'b0);
        drain_results();
        write_reg(REG_SUBSET_SIZE, 7'd2);
        send_request(1'b0);
        configure(7'd64, 7'd64);
        send_request(1'b0);
        configure(7'd127, 7'd1);
        send_request(1'b1);
        send_request(1'b0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0, 1: begin
                    n_val = $urandom_range(64, 127);
                    k_val = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(60, 64);
                end
                2: begin
                    n_val = $urandom_range(0, 12);
                    k_val = $urandom_range(1) ? 0 : n_val + $urandom_range(1, 3);
                end
                3: begin
                    n_val = $urandom_range(11, 40);
                    k_val = $urandom_range(1, n_val);
                end
                default: begin
                    n_val = $urandom_range(1, 10);
                    k_val = $urandom_range(1, n_val);
                end
            endcase
            phase_items = (k_val > 16) ? $urandom_range(2, 8) : $urandom_range(10, 40);
            if (phase == 4) begin
                n_val = 10;
                k_val = 5;
                phase_items = 30;
            end
            configure(7'(n_val), 7'(k_val));
            tx_steady = (phase == 2) || (phase == 4);
            rx_steady = (phase == 2);
            if (phase == 4) begin
                rx_hold_req = 1'b1;
            end
            for (j = 0; j < phase_items; j++) begin
                if (phase == 6 && j == phase_items / 2) begin
                    drain_results();
                end
                send_request($urandom_range(9) == 0);
                sent++;
            end
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            phase++;
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (track.mismatches == 0 && track.due_indices.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
